// File: rtl/ttb_pkg.sv
// shared types and constants for the triangle tangent basis block
`default_nettype none
package ttb_pkg;

  localparam int unsigned InBits   = 208;
  localparam int unsigned OutBits  = 48;
  localparam int unsigned UserBits = 2;
  localparam int unsigned ScaleBits = 30;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_DET,
    S_SD,
    S_TD,
    S_SCALE,
    S_CR,
    S_DOT,
    S_DP,
    S_TV,
    S_SQ,
    S_SQRT,
    S_DIVSET,
    S_DIV,
    S_OUT
  } ttb_state_t;

endpackage
`default_nettype wire

// File: rtl/triangle_tangent_basis.sv
// per-vertex tangent and handedness for a de-indexed triangle stream
// vertices one and two of a triangle are only held; the third starts the computation, and no
// input is taken until all three result beats are out, out_tready stalls included; the work
// runs on the shared 32x32 multiply-accumulate, the halving loop of the block scaling, the
// 32-step square root and 16-step division per component (skipped for a degenerate tangent)
// one triangle in flight; rst_n (synchronous) empties the vertex holding slots
`default_nettype none
module triangle_tangent_basis
  import ttb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v (32 bit each), norm_x, norm_y, norm_z (16 bit)
  input  wire logic [InBits-1:0]   in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // tan_x, tan_y, tan_z (16 bit each)
  output logic [OutBits-1:0]       out_tdata,
  // flip_handed, degenerate
  output logic [UserBits-1:0]      out_tuser,
  output logic                     out_tlast
);

  ttb_state_t state_r, state_nxt, ret_r;

  logic [1:0] slot_r;
  logic       ph_r;
  logic [1:0] term_r;
  logic [1:0] i_r;
  logic [1:0] v_r;
  logic [3:0] cnt_r;

  logic signed [31:0] pos_r [3][3];
  logic signed [31:0] uv_r  [3][2];
  logic signed [15:0] nrm_r [3][3];

  logic signed [31:0] x1_r [3];
  logic signed [31:0] x2_r [3];
  logic signed [31:0] s1_r, s2_r, t1_r, t2_r;

  logic               neg_r, dz_r;
  logic signed [30:0] sd_r [3];
  logic signed [30:0] td_r [3];
  logic signed [30:0] cr_r [3];
  logic signed [48:0] d_r;
  logic signed [65:0] vec_r [3];
  logic signed [65:0] acc_r;
  logic signed [63:0] prod_r;

  logic [63:0] x_r, r_r, bit_r;
  logic [31:0] len_r;
  logic [15:0] num_r, q_r;

  logic signed [15:0] tan_r [3];
  logic               flip_r, degen_r;

  // multiply-accumulate unit
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               t_sub, t_half, t_sh;
  logic [1:0]         t_last;
  logic               mac_st, mac_done;
  logic signed [65:0] p66, term_v, acc_sum;

  // shared compare and subtract
  logic [63:0] cs_a, cs_b, cs_diff;
  logic        cs_ge;

  logic        big;
  logic [1:0]  wslot;
  logic [30:0] mag31;
  logic [46:0] num_full;
  logic [15:0] q_nxt;
  logic [63:0] r_nxt;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -33'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] ext16(input logic signed [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [31:0] ext31(input logic signed [30:0] v);
    return {v[30], v};
  endfunction

  function automatic logic [1:0] nx3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic signed [65:0] halve(input logic signed [65:0] v);
    return (v + $signed({65'd0, v[65]})) >>> 1;
  endfunction

  function automatic logic is_big(input logic signed [65:0] v);
    return (v >= (66'sd1 <<< ScaleBits)) || (v <= -(66'sd1 <<< ScaleBits));
  endfunction

  function automatic logic signed [31:0] hs(input logic n, input logic signed [30:0] v);
    return n ? -ext31(v) : ext31(v);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {tan_r[2], tan_r[1], tan_r[0]};
  assign out_tuser  = {degen_r, flip_r};
  assign out_tlast  = (v_r == 2'd2);

  assign wslot = slot_r[1] ? 2'd2 : slot_r;

  // operand selection per step
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    t_sub  = 1'b0;
    t_half = 1'b0;
    t_sh   = 1'b0;
    t_last = 2'd2;
    mac_st = 1'b1;
    unique case (state_r)
      S_DET: begin
        t_last = 2'd1;
        if (term_r == 2'd0) begin
          mul_a = s1_r; mul_b = t2_r;
        end else begin
          mul_a = s2_r; mul_b = t1_r; t_sub = 1'b1;
        end
      end
      S_SD: begin
        t_last = 2'd1; t_half = 1'b1;
        if (term_r == 2'd0) begin
          mul_a = t2_r; mul_b = x1_r[i_r];
        end else begin
          mul_a = t1_r; mul_b = x2_r[i_r]; t_sub = 1'b1;
        end
      end
      S_TD: begin
        t_last = 2'd1; t_half = 1'b1;
        if (term_r == 2'd0) begin
          mul_a = s1_r; mul_b = x2_r[i_r];
        end else begin
          mul_a = s2_r; mul_b = x1_r[i_r]; t_sub = 1'b1;
        end
      end
      S_CR: begin
        t_last = 2'd1;
        if (term_r == 2'd0) begin
          mul_a = ext16(nrm_r[v_r][nx3(i_r)]); mul_b = ext31(sd_r[nx3(nx3(i_r))]);
        end else begin
          mul_a = ext16(nrm_r[v_r][nx3(nx3(i_r))]); mul_b = ext31(sd_r[nx3(i_r)]);
          t_sub = 1'b1;
        end
      end
      S_DOT: begin
        mul_a = ext31(cr_r[term_r]); mul_b = ext31(td_r[term_r]);
      end
      S_DP: begin
        mul_a = ext16(nrm_r[v_r][term_r]); mul_b = hs(neg_r, sd_r[term_r]);
      end
      S_TV: begin
        if (term_r == 2'd0) begin
          mul_a = hs(neg_r, sd_r[i_r]); mul_b = 32'sd268435456;
        end else if (term_r == 2'd1) begin
          mul_a = ext16(nrm_r[v_r][i_r]); mul_b = {8'd0, d_r[23:0]}; t_sub = 1'b1;
        end else begin
          mul_a = ext16(nrm_r[v_r][i_r]); mul_b = {{7{d_r[48]}}, d_r[48:24]};
          t_sub = 1'b1; t_sh = 1'b1;
        end
      end
      S_SQ: begin
        mul_a = vec_r[term_r][31:0]; mul_b = vec_r[term_r][31:0];
      end
      default: mac_st = 1'b0;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign mac_done = mac_st && ph_r && (term_r == t_last);
  assign p66      = {{2{prod_r[63]}}, prod_r};

  always_comb begin
    term_v = p66;
    if (t_half) begin
      term_v = halve(p66);
    end
    if (t_sh) begin
      term_v = p66 <<< 24;
    end
    acc_sum = ((term_r == 2'd0) ? 66'sd0 : acc_r) + (t_sub ? -term_v : term_v);
  end

  assign big = is_big(vec_r[0]) || is_big(vec_r[1]) || is_big(vec_r[2]);

  always_comb begin
    if (state_r == S_SQRT) begin
      cs_a = x_r;
      cs_b = r_r + bit_r;
    end else begin
      cs_a = {x_r[62:0], num_r[15]};
      cs_b = {31'd0, len_r, 1'b0};
    end
    cs_ge   = cs_a >= cs_b;
    cs_diff = cs_a - cs_b;
  end

  assign r_nxt    = cs_ge ? (r_r >> 1) + bit_r : r_r >> 1;
  assign q_nxt    = {q_r[14:0], cs_ge};
  assign mag31    = vec_r[i_r][65] ? 31'(-vec_r[i_r][30:0]) : vec_r[i_r][30:0];
  assign num_full = {2'd0, mag31[29:0], 15'd0} + {15'd0, len_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid && slot_r[1]) state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_DET;
      S_DET:    if (mac_done) state_nxt = S_SD;
      S_SD, S_TD, S_CR: if (mac_done && i_r == 2'd2) state_nxt = S_SCALE;
      S_SCALE: begin
        if (!big) begin
          unique case (ret_r)
            S_SD:    state_nxt = S_TD;
            S_TD:    state_nxt = S_CR;
            S_CR:    state_nxt = S_DOT;
            default: state_nxt = S_SQ;
          endcase
        end
      end
      S_DOT:    if (mac_done) state_nxt = dz_r ? S_OUT : S_DP;
      S_DP:     if (mac_done) state_nxt = S_TV;
      S_TV: begin
        if (mac_done && i_r == 2'd2) begin
          if (vec_r[0] == '0 && vec_r[1] == '0 && acc_sum == '0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCALE;
          end
        end
      end
      S_SQ:     if (mac_done) state_nxt = S_SQRT;
      S_SQRT:   if (bit_r[0]) state_nxt = S_DIVSET;
      S_DIVSET: state_nxt = S_DIV;
      S_DIV:    if (cnt_r == 4'd15) state_nxt = (i_r == 2'd2) ? S_OUT : S_DIVSET;
      S_OUT:    if (out_tready) state_nxt = (v_r == 2'd2) ? S_IDLE : S_CR;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= 2'd0;
      ph_r    <= 1'b0;
      term_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (in_tvalid && in_tready) begin
        slot_r <= slot_r[1] ? 2'd0 : slot_r + 2'd1;
      end
      if (mac_st) begin
        ph_r <= !ph_r;
        if (ph_r) begin
          term_r <= (term_r == t_last) ? 2'd0 : term_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_st && !ph_r) begin
      prod_r <= mul_p;
    end
    if (mac_st && ph_r) begin
      acc_r <= acc_sum;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          pos_r[wslot][0] <= in_tdata[31:0];
          pos_r[wslot][1] <= in_tdata[63:32];
          pos_r[wslot][2] <= in_tdata[95:64];
          uv_r[wslot][0]  <= in_tdata[127:96];
          uv_r[wslot][1]  <= in_tdata[159:128];
          nrm_r[wslot][0] <= in_tdata[175:160];
          nrm_r[wslot][1] <= in_tdata[191:176];
          nrm_r[wslot][2] <= in_tdata[207:192];
        end
      end
      S_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          x1_r[k] <= sat32({pos_r[1][k][31], pos_r[1][k]} - {pos_r[2][k][31], pos_r[2][k]});
          x2_r[k] <= sat32({pos_r[0][k][31], pos_r[0][k]} - {pos_r[2][k][31], pos_r[2][k]});
        end
        s1_r <= sat32({uv_r[1][0][31], uv_r[1][0]} - {uv_r[2][0][31], uv_r[2][0]});
        s2_r <= sat32({uv_r[0][0][31], uv_r[0][0]} - {uv_r[2][0][31], uv_r[2][0]});
        t1_r <= sat32({uv_r[1][1][31], uv_r[1][1]} - {uv_r[2][1][31], uv_r[2][1]});
        t2_r <= sat32({uv_r[0][1][31], uv_r[0][1]} - {uv_r[2][1][31], uv_r[2][1]});
        i_r  <= 2'd0;
        v_r  <= 2'd0;
      end
      S_DET: begin
        if (mac_done) begin
          neg_r <= acc_sum < 0;
          dz_r  <= acc_sum == '0;
        end
      end
      S_SD, S_TD, S_CR: begin
        if (mac_done) begin
          vec_r[i_r] <= acc_sum;
          i_r        <= nx3(i_r);
          ret_r      <= state_r;
        end
      end
      S_SCALE: begin
        if (big) begin
          for (int k = 0; k < 3; k++) begin
            vec_r[k] <= halve(vec_r[k]);
          end
        end else begin
          for (int k = 0; k < 3; k++) begin
            unique case (ret_r)
              S_SD:    sd_r[k] <= vec_r[k][30:0];
              S_TD:    td_r[k] <= vec_r[k][30:0];
              S_CR:    cr_r[k] <= vec_r[k][30:0];
              default: ;
            endcase
          end
        end
      end
      S_DOT: begin
        if (mac_done) begin
          flip_r <= (acc_sum < 0) && !dz_r;
          if (dz_r) begin
            degen_r <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              tan_r[k] <= '0;
            end
          end
        end
      end
      S_DP: begin
        if (mac_done) begin
          d_r <= acc_sum[48:0];
        end
      end
      S_TV: begin
        if (mac_done) begin
          vec_r[i_r] <= acc_sum;
          i_r        <= nx3(i_r);
          ret_r      <= S_TV;
          // exact zero after orthogonalising
          if (i_r == 2'd2 && vec_r[0] == '0 && vec_r[1] == '0 && acc_sum == '0) begin
            degen_r <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              tan_r[k] <= '0;
            end
          end
        end
      end
      S_SQ: begin
        if (mac_done) begin
          x_r     <= acc_sum[63:0];
          r_r     <= '0;
          bit_r   <= 64'd1 << 62;
          degen_r <= 1'b0;
        end
      end
      S_SQRT: begin
        if (cs_ge) begin
          x_r <= cs_diff;
        end
        r_r   <= r_nxt;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          len_r <= r_nxt[31:0];
          i_r   <= 2'd0;
        end
      end
      S_DIVSET: begin
        x_r   <= {33'd0, num_full[46:16]};
        num_r <= num_full[15:0];
        q_r   <= '0;
        cnt_r <= 4'd0;
      end
      S_DIV: begin
        x_r   <= cs_ge ? cs_diff : cs_a;
        num_r <= {num_r[14:0], 1'b0};
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          tan_r[i_r] <= vec_r[i_r][65] ? -q_nxt : q_nxt;
          i_r        <= nx3(i_r);
        end
      end
      S_OUT: begin
        if (out_tready) begin
          v_r <= nx3(v_r);
          i_r <= 2'd0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// self-checking testbench for triangle_tangent_basis: vertex stream in, predicted tangents out
module tb;
  import ttb_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, pz, tu, tv;
    logic signed [15:0] nx, ny, nz;
    bit                 drain;
  } vertex_t;

  typedef struct {
    logic [15:0] tx, ty, tz;
    bit          flip, degen, last;
  } tangent_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InBits-1:0]   in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutBits-1:0]  out_tdata;
  logic [UserBits-1:0] out_tuser;
  logic                out_tlast;

  vertex_t  vertex_q[$];
  tangent_t tangent_q[$];
  vertex_t  cur_vtx;
  bit       in_took = 1'b0;
  int       n_taken = 0;
  int       n_errors = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit       stim_done = 1'b0;

  // held vertices of the triangle being assembled
  longint   held_p[2][3];
  longint   held_uv[2][2];
  longint   held_n[2][3];
  int       held_cnt = 0;

  triangle_tangent_basis i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #4 clk = ~clk;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // shrink by a power of two until every component is below 2^30
  task automatic scale3(inout longint a, inout longint b, inout longint c);
    longint unsigned m;
    int     k;
    longint d;
    m = mag(a);
    if (mag(b) > m) m = mag(b);
    if (mag(c) > m) m = mag(c);
    k = 0;
    while ((m >> k) >= (64'd1 << 30)) k++;
    if (k != 0) begin
      d = longint'(1) << k;
      a = a / d;
      b = b / d;
      c = c / d;
    end
  endtask

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // orthogonalise against the normal and normalise to q1.14, returns 1 when zero
  task automatic ortho_tangent(input longint s[3], input longint n[3], output longint o[3],
                               output bit zero);
    longint          t[3];
    longint          d;
    longint unsigned sum, len, q;
    d = n[0] * s[0] + n[1] * s[1] + n[2] * s[2];
    for (int i = 0; i < 3; i++) t[i] = s[i] * 64'sd268435456 - n[i] * d;
    o = '{0, 0, 0};
    zero = (t[0] == 0 && t[1] == 0 && t[2] == 0);
    if (!zero) begin
      scale3(t[0], t[1], t[2]);
      sum = 0;
      for (int i = 0; i < 3; i++) sum += mag(t[i]) * mag(t[i]);
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = (mag(t[i]) * 32768 + len) / (2 * len);
        o[i] = (t[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endtask

  task automatic predict_vertex(input vertex_t vx);
    longint   p[3][3], uv[3][2], nr[3][3];
    longint   x1[3], x2[3], sd[3], td[3], hs[3], cr[3], tg[3];
    longint   s1, s2, t1, t2, ps, pt, dp;
    bit       neg, degen, flip;
    tangent_t r;
    if (held_cnt < 2) begin
      held_p[held_cnt] = '{vx.px, vx.py, vx.pz};
      held_uv[held_cnt] = '{vx.tu, vx.tv};
      held_n[held_cnt] = '{vx.nx, vx.ny, vx.nz};
      held_cnt++;
      return;
    end
    held_cnt = 0;
    for (int v = 0; v < 2; v++) begin
      p[v] = held_p[v];
      uv[v] = held_uv[v];
      nr[v] = held_n[v];
    end
    p[2] = '{vx.px, vx.py, vx.pz};
    uv[2] = '{vx.tu, vx.tv};
    nr[2] = '{vx.nx, vx.ny, vx.nz};
    for (int i = 0; i < 3; i++) begin
      x1[i] = sat32(p[1][i] - p[2][i]);
      x2[i] = sat32(p[0][i] - p[2][i]);
    end
    s1 = sat32(uv[1][0] - uv[2][0]);
    s2 = sat32(uv[0][0] - uv[2][0]);
    t1 = sat32(uv[1][1] - uv[2][1]);
    t2 = sat32(uv[0][1] - uv[2][1]);
    ps = s1 * t2;
    pt = s2 * t1;
    neg = ps < pt;
    for (int i = 0; i < 3; i++) begin
      sd[i] = (t2 * x1[i]) / 2 - (t1 * x2[i]) / 2;
      td[i] = (s1 * x2[i]) / 2 - (s2 * x1[i]) / 2;
    end
    scale3(sd[0], sd[1], sd[2]);
    scale3(td[0], td[1], td[2]);
    for (int i = 0; i < 3; i++) hs[i] = neg ? -sd[i] : sd[i];
    for (int v = 0; v < 3; v++) begin
      cr[0] = nr[v][1] * sd[2] - nr[v][2] * sd[1];
      cr[1] = nr[v][2] * sd[0] - nr[v][0] * sd[2];
      cr[2] = nr[v][0] * sd[1] - nr[v][1] * sd[0];
      scale3(cr[0], cr[1], cr[2]);
      dp = cr[0] * td[0] + cr[1] * td[1] + cr[2] * td[2];
      if (ps == pt) begin
        tg = '{0, 0, 0};
        degen = 1'b1;
        flip = 1'b0;
      end else begin
        ortho_tangent(hs, nr[v], tg, degen);
        flip = dp < 0;
      end
      r.tx = tg[0][15:0];
      r.ty = tg[1][15:0];
      r.tz = tg[2][15:0];
      r.flip = flip;
      r.degen = degen;
      r.last = (v == 2);
      tangent_q = {tangent_q, r};
    end
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  task automatic add_vertex(input vertex_t v);
    vertex_q = {vertex_q, v};
  endtask

  function automatic vertex_t mk_vertex(longint px, longint py, longint pz, longint tu,
                                        longint tv, int nx, int ny, int nz);
    vertex_t v;
    v.px = px[31:0]; v.py = py[31:0]; v.pz = pz[31:0]; v.tu = tu[31:0]; v.tv = tv[31:0];
    v.nx = nx[15:0]; v.ny = ny[15:0]; v.nz = nz[15:0];
    v.drain = 1'b0;
    return v;
  endfunction

  function automatic int rand_norm();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic int rand_small();
    return int'($urandom_range(0, 2000000)) - 1000000;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_took) begin
        if (vertex_q.size() != 0 && !(vertex_q[0].drain && tangent_q.size() != 0)
            && ((n_taken > 150 && n_taken < 260) || $urandom_range(0, 99) >= 8)) begin
          cur_vtx <= vertex_q[0];
          in_tdata <= {vertex_q[0].nz, vertex_q[0].ny, vertex_q[0].nx, vertex_q[0].tv,
                       vertex_q[0].tu, vertex_q[0].pz, vertex_q[0].py, vertex_q[0].px};
          in_tvalid <= 1'b1;
          vertex_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure, with one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && n_taken >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 3000;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (n_taken > 150 && n_taken < 260) || $urandom_range(0, 99) >= 8;
      end
    end
  end

  // monitor: accept input beats into the predictor, check result beats
  always @(posedge clk) begin
    tangent_t w;
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took) begin
      predict_vertex(cur_vtx);
      n_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (tangent_q.size() == 0) begin
        report("unexpected beat", out_tdata[15:0], 16'd0);
      end else begin
        w = tangent_q.pop_front();
        if (out_tdata[15:0] !== w.tx) report("tan_x", out_tdata[15:0], w.tx);
        if (out_tdata[31:16] !== w.ty) report("tan_y", out_tdata[31:16], w.ty);
        if (out_tdata[47:32] !== w.tz) report("tan_z", out_tdata[47:32], w.tz);
        if (out_tuser[0] !== w.flip)
          report("flip_handed", {15'd0, out_tuser[0]}, {15'd0, w.flip});
        if (out_tuser[1] !== w.degen)
          report("degenerate", {15'd0, out_tuser[1]}, {15'd0, w.degen});
        if (out_tlast !== w.last)
          report("last_of_triangle", {15'd0, out_tlast}, {15'd0, w.last});
      end
    end
  end

  initial begin
    vertex_t v;
    int      base;
    // plain right-handed triangle
    add_vertex(mk_vertex(0, 0, 0, 0, 0, 0, 0, 16384));
    add_vertex(mk_vertex(65536, 0, 0, 65536, 0, 0, 0, 16384));
    add_vertex(mk_vertex(0, 65536, 0, 0, 65536, 0, 0, 16384));
    // mirrored uv, positive determinant
    add_vertex(mk_vertex(0, 0, 0, 0, 0, 0, 0, -16384));
    add_vertex(mk_vertex(65536, 0, 0, -65536, 0, 0, 0, -16384));
    add_vertex(mk_vertex(0, 65536, 0, 0, 65536, 0, 0, -16384));
    // identical uv: zero determinant
    add_vertex(mk_vertex(1, 2, 3, 7, 7, 16384, 0, 0));
    add_vertex(mk_vertex(40000, -5, 9, 7, 7, 0, 16384, 0));
    add_vertex(mk_vertex(-3, 90000, 1, 7, 7, 0, 0, 16384));
    // normal along the tangent: zero after orthogonalising
    add_vertex(mk_vertex(0, 0, 0, 0, 0, 16384, 0, 0));
    add_vertex(mk_vertex(65536, 0, 0, 65536, 0, -16384, 0, 0));
    add_vertex(mk_vertex(0, 65536, 0, 0, 65536, 16384, 0, 0));
    // extreme coordinates: saturated differences, non-unit normals
    add_vertex(mk_vertex(-2147483648, 2147483647, -2147483648, 2147483647,
                         -2147483648, -16384, -16384, -16384));
    add_vertex(mk_vertex(2147483647, -2147483648, 2147483647, -2147483648,
                         2147483647, 16384, 16384, 16384));
    add_vertex(mk_vertex(-2147483648, -2147483648, 2147483647, 2147483647,
                         2147483647, 0, 0, 0));
    add_vertex(mk_vertex(2147483647, 2147483647, 2147483647, -2147483648,
                         -2147483648, 16384, -16384, 5));
    add_vertex(mk_vertex(-1, -1, -1, -1, -1, -1, -1, -1));
    add_vertex(mk_vertex(0, 0, 0, 0, 1, 1, 0, 0));
    for (int t = 0; t < 144; t++) begin
      base = rand_small();
      for (int k = 0; k < 3; k++) begin
        if (t % 6 == 5)
          v = mk_vertex(longint'(int'($urandom())), longint'(int'($urandom())),
                        longint'(int'($urandom())), longint'(int'($urandom())),
                        longint'(int'($urandom())), rand_norm(), rand_norm(), rand_norm());
        else
          v = mk_vertex(base + rand_small(), base + rand_small(), rand_small(),
                        rand_small(), rand_small(), rand_norm(), rand_norm(), rand_norm());
        // let the block run dry once mid-stream
        v.drain = (t == 60 && k == 0);
        add_vertex(v);
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (vertex_q.size() == 0 && !in_tvalid);
    wait (tangent_q.size() == 0);
    repeat (1000) @(posedge clk);
    stim_done = 1'b1;
    if (n_errors == 0 && tangent_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #16000000;
    if (!stim_done) begin
      $display("timeout at %0t", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

// File: triangle_tangent_basis.f
rtl/ttb_pkg.sv
rtl/triangle_tangent_basis.sv
tb/sv/tb.sv
